>>> rtl/kuznyechik_block_cipher_unit_macros.svh
// Assertion macros for the cipher unit checker
`ifndef KUZNYECHIK_BLOCK_CIPHER_UNIT_MACROS_SVH
`define KUZNYECHIK_BLOCK_CIPHER_UNIT_MACROS_SVH
// implication, one clock, synchronous active-low reset
`define KZ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define KZ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/kuz_pkg.sv
// ----------------------------------------------------------------------------
// kuz_pkg
// Types, constants and GF(2^8) helpers for the Kuznyechik cipher unit.
// ----------------------------------------------------------------------------
package kuz_pkg;

    localparam int unsigned BLK_W = 128;
    localparam int unsigned KEY_REG_W = 64;
    localparam int unsigned NUM_RKEYS = 10;
    localparam int unsigned KS_ROUNDS = 32;

    typedef logic [BLK_W-1:0] t_blk;
    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_K1_HI = 2'd0;
    localparam t_cfg_idx CFG_K1_LO = 2'd1;
    localparam t_cfg_idx CFG_K2_HI = 2'd2;
    localparam t_cfg_idx CFG_K2_LO = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KSCHED,
        ST_ENC,
        ST_DEC,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_KS_STEP,
        CMD_ENC_STEP,
        CMD_DEC_STEP
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd     cmd;
        logic [4:0]  ks_idx;
        logic [3:0]  rk_idx;
        logic        first;
        logic        last;
    } t_ctrl;

    localparam logic [7:0] SBOX [256] = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
        8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
        8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
        8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
        8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
        8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
        8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
        8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
        8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
        8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
        8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
        8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
        8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
        8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
        8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
        8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
        8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
    };

    localparam logic [7:0] LCOEF [16] = '{
        8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
        8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
    };

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) x = x ^ 9'h1C3;
        end
        return acc;
    endfunction

    function automatic logic [7:0] sbox_inv(input logic [7:0] y);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 256; i++) begin
            if (SBOX[i] == y) r = 8'(i);
        end
        return r;
    endfunction

    function automatic logic [7:0] lin_sum(input t_blk v);
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < 16; i++) s = s ^ gf_mul(LCOEF[i], v[8*i +: 8]);
        return s;
    endfunction

    function automatic t_blk lin_fwd(input t_blk v);
        t_blk t;
        t = v;
        for (int r = 0; r < 16; r++) t = {lin_sum(t), t[BLK_W-1:8]};
        return t;
    endfunction

    function automatic t_blk lin_inv(input t_blk v);
        t_blk t;
        t = v;
        for (int r = 0; r < 16; r++) t = {t[BLK_W-9:0], lin_sum({t[BLK_W-9:0], t[BLK_W-1 -: 8]})};
        return t;
    endfunction

    function automatic t_blk sub_fwd(input t_blk v);
        t_blk t;
        for (int i = 0; i < 16; i++) t[8*i +: 8] = SBOX[v[8*i +: 8]];
        return t;
    endfunction

    function automatic t_blk sub_inv(input t_blk v);
        t_blk t;
        for (int i = 0; i < 16; i++) t[8*i +: 8] = sbox_inv(v[8*i +: 8]);
        return t;
    endfunction

    function automatic t_blk ks_const(input logic [4:0] idx);
        return lin_fwd({120'd0, 3'd0, idx} + t_blk'(1));
    endfunction

endpackage

>>> rtl/kuz_ctrl.sv
// ----------------------------------------------------------------------------
// kuz_ctrl
// Sequencer: key schedule, then ten encryption or decryption round steps.
// ----------------------------------------------------------------------------
module kuz_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_opcode,
    input  logic            i_out_stall,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output kuz_pkg::t_ctrl  o_ctrl
);

    kuz_pkg::t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_dec, n_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kuz_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_dec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dec   <= n_dec;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_dec = r_dec;
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;
        o_ctrl = '{cmd: kuz_pkg::CMD_NONE, ks_idx: r_cnt, rk_idx: r_cnt[3:0],
                   first: (r_cnt == '0), last: 1'b0};
        unique case (r_state)
            kuz_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctrl.cmd = kuz_pkg::CMD_LOAD;
                    n_dec = i_opcode;
                    n_cnt = '0;
                    n_state = kuz_pkg::ST_KSCHED;
                end
            end
            kuz_pkg::ST_KSCHED: begin
                o_ctrl.cmd = kuz_pkg::CMD_KS_STEP;
                o_ctrl.last = (r_cnt[2:0] == 3'd7);
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(kuz_pkg::KS_ROUNDS - 1)) begin
                    n_cnt = '0;
                    n_state = r_dec ? kuz_pkg::ST_DEC : kuz_pkg::ST_ENC;
                end
            end
            kuz_pkg::ST_ENC, kuz_pkg::ST_DEC: begin
                o_ctrl.cmd = (r_state == kuz_pkg::ST_ENC) ? kuz_pkg::CMD_ENC_STEP
                                                          : kuz_pkg::CMD_DEC_STEP;
                o_ctrl.rk_idx = (r_state == kuz_pkg::ST_ENC) ? r_cnt[3:0]
                                                             : 4'(9 - r_cnt[3:0]);
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(kuz_pkg::NUM_RKEYS - 1)) begin
                    n_state = kuz_pkg::ST_DONE;
                end
            end
            kuz_pkg::ST_DONE: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = kuz_pkg::ST_IDLE;
                end
            end
            default: n_state = kuz_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> rtl/kuz_dp.sv
// ----------------------------------------------------------------------------
// kuz_dp
// Datapath: key registers, key schedule, round key store and round unit.
// ----------------------------------------------------------------------------
module kuz_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  kuz_pkg::t_ctrl        i_ctrl,
    input  kuz_pkg::t_blk         i_block,
    output kuz_pkg::t_blk         o_result
);

    logic [63:0] r_k1h, r_k1l, r_k2h, r_k2l;
    kuz_pkg::t_blk r_a, r_b, r_v, n_v, r_ks_c, n_a;
    kuz_pkg::t_blk r_rk [kuz_pkg::NUM_RKEYS];
    kuz_pkg::t_blk rk_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1h <= '0;
            r_k1l <= '0;
            r_k2h <= '0;
            r_k2l <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kuz_pkg::CFG_K1_HI: r_k1h <= i_cfg_data;
                kuz_pkg::CFG_K1_LO: r_k1l <= i_cfg_data;
                kuz_pkg::CFG_K2_HI: r_k2h <= i_cfg_data;
                kuz_pkg::CFG_K2_LO: r_k2l <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Feistel step: n_a = L(S(a ^ C)) ^ b; the next step's constant is registered during the current step
    assign n_a = kuz_pkg::lin_fwd(kuz_pkg::sub_fwd(r_a ^ r_ks_c)) ^ r_b;
    assign rk_sel = r_rk[i_ctrl.rk_idx];

    always_comb begin
        n_v = r_v;
        case (i_ctrl.cmd)
            kuz_pkg::CMD_LOAD:
                n_v = i_block;
            kuz_pkg::CMD_ENC_STEP:
                n_v = i_ctrl.first ? (r_v ^ rk_sel)
                     : (kuz_pkg::lin_fwd(kuz_pkg::sub_fwd(r_v)) ^ rk_sel);
            kuz_pkg::CMD_DEC_STEP:
                n_v = i_ctrl.first ? (r_v ^ rk_sel)
                     : (kuz_pkg::sub_inv(kuz_pkg::lin_inv(r_v)) ^ rk_sel);
            default: n_v = r_v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        case (i_ctrl.cmd)
            kuz_pkg::CMD_LOAD: begin
                r_a <= {r_k1h, r_k1l};
                r_b <= {r_k2h, r_k2l};
                r_rk[0] <= {r_k1h, r_k1l};
                r_rk[1] <= {r_k2h, r_k2l};
                r_ks_c <= kuz_pkg::ks_const(5'd0);
            end
            kuz_pkg::CMD_KS_STEP: begin
                r_a <= n_a;
                r_b <= r_a;
                r_ks_c <= kuz_pkg::ks_const(i_ctrl.ks_idx + 5'd1);
                if (i_ctrl.last) begin
                    r_rk[{i_ctrl.ks_idx[4:3], 1'b0} + 4'd2] <= n_a;
                    r_rk[{i_ctrl.ks_idx[4:3], 1'b0} + 4'd3] <= r_a;
                end
            end
            default: ;
        endcase
    end

    assign o_result = r_v;

endmodule

>>> rtl/kuznyechik_block_cipher_unit.sv
// The result is valid after the input transaction has gone through 32 key schedule
// steps and then 10 round steps; one block at a time, so a new block is accepted
// only after the result transaction and a return to idle. Key schedule and round
// steps run one step a cycle and do not stall.
// Reset (synchronous, active low) clears the key registers and controller.
// ----------------------------------------------------------------------------
// kuznyechik_block_cipher_unit
// Kuznyechik 128-bit block cipher, encrypt or decrypt, 256-bit key.
// ----------------------------------------------------------------------------
module kuznyechik_block_cipher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);

    kuz_pkg::t_ctrl ctrl;
    kuz_pkg::t_blk  result;

    kuz_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_stall),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_ctrl      (ctrl)
    );

    kuz_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (ctrl),
        .i_block    ({i_block_high, i_block_low}),
        .o_result   (result)
    );

    assign o_result_high = result[127:64];
    assign o_result_low  = result[63:0];

endmodule

>>> rtl/kuz_chk.sv
// ----------------------------------------------------------------------------
// kuz_chk
// Port-level checker for the cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "kuznyechik_block_cipher_unit_macros.svh"
module kuz_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_result_high,
    input logic [63:0] o_result_low
);
    `KZ_ASSERT_IMP(a_busy_excl, i_clk, i_rst_n, o_valid, o_stall, "result while ready")
    `KZ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall && !o_valid, "not busy after accept")
    `KZ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result_high) && $stable(o_result_low), "result dropped")
    `KZ_ASSERT_NXT(a_out_done, i_clk, i_rst_n, o_valid && !i_stall, !o_valid && !o_stall, "no return to ready")
endmodule

bind kuznyechik_block_cipher_unit kuz_chk u_kuz_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_result_high (o_result_high),
    .o_result_low  (o_result_low)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Kuznyechik cipher unit testbench
// Drives encrypt and decrypt transactions under several keys, predicts each
// block with an independent cipher model and checks results in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        op;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_txn;

    typedef logic [7:0] t_bytes [16];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_opcode = 1'b0;
    logic [63:0] i_block_high = '0;
    logic [63:0] i_block_low = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;

    kuznyechik_block_cipher_unit i_dut (.*);

    always #6 i_clk = ~i_clk;

    t_txn        pending_q[$];
    logic [63:0] cipher_exp_q[$];
    logic [63:0] key_regs [4];
    int          n_errors = 0;
    int          n_results = 0;
    int          n_enc = 0;
    int          n_dec = 0;
    int          n_keys = 0;
    int          cycle_cnt = 0;
    bit          no_idle = 1'b0;

    localparam logic [7:0] S_TAB [256] = '{
        252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
        233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
        249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
        5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
        235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
        181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
        21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
        50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
        223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
        224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
        167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
        173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
        7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
        225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
        32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
        89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
    };
    localparam logic [7:0] MIX_W [16] = '{
        1, 148, 32, 133, 16, 194, 192, 1, 251, 1, 192, 194, 16, 133, 32, 148
    };

    logic [7:0] s_rev [256];
    initial for (int i = 0; i < 256; i++) s_rev[S_TAB[i]] = 8'(i);

    function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= x[7:0];
            x = x << 1;
            if (x[8]) x ^= 9'h1C3;
        end
        return acc;
    endfunction

    function automatic logic [7:0] mix_byte(t_bytes v);
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < 16; i++) s ^= field_mul(MIX_W[i], v[i]);
        return s;
    endfunction

    function automatic t_bytes diffuse(t_bytes v);
        logic [7:0] n;
        for (int r = 0; r < 16; r++) begin
            n = mix_byte(v);
            for (int i = 0; i < 15; i++) v[i] = v[i+1];
            v[15] = n;
        end
        return v;
    endfunction

    function automatic t_bytes undiffuse(t_bytes v);
        t_bytes rot;
        for (int r = 0; r < 16; r++) begin
            rot[0] = v[15];
            for (int i = 1; i < 16; i++) rot[i] = v[i-1];
            for (int i = 15; i > 0; i--) v[i] = v[i-1];
            v[0] = mix_byte(rot);
        end
        return v;
    endfunction

    function automatic t_bytes to_bytes(logic [63:0] hi, logic [63:0] lo);
        t_bytes v;
        for (int i = 0; i < 8; i++) begin
            v[i] = lo[8*i +: 8];
            v[i+8] = hi[8*i +: 8];
        end
        return v;
    endfunction

    function automatic logic [127:0] cipher_block(logic op, logic [63:0] hi, logic [63:0] lo);
        t_bytes rk [10];
        t_bytes a, b, t, c, v;
        logic [127:0] res;
        rk[0] = to_bytes(key_regs[kuz_pkg::CFG_K1_HI], key_regs[kuz_pkg::CFG_K1_LO]);
        rk[1] = to_bytes(key_regs[kuz_pkg::CFG_K2_HI], key_regs[kuz_pkg::CFG_K2_LO]);
        a = rk[0];
        b = rk[1];
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 8; j++) begin
                for (int n = 0; n < 16; n++) c[n] = '0;
                c[0] = 8'(8*i + j + 1);
                c = diffuse(c);
                for (int n = 0; n < 16; n++) t[n] = S_TAB[a[n] ^ c[n]];
                t = diffuse(t);
                for (int n = 0; n < 16; n++) t[n] ^= b[n];
                b = a;
                a = t;
            end
            rk[2*i+2] = a;
            rk[2*i+3] = b;
        end
        v = to_bytes(hi, lo);
        if (!op) begin
            for (int n = 0; n < 16; n++) v[n] ^= rk[0][n];
            for (int r = 1; r < 10; r++) begin
                for (int n = 0; n < 16; n++) v[n] = S_TAB[v[n]];
                v = diffuse(v);
                for (int n = 0; n < 16; n++) v[n] ^= rk[r][n];
            end
        end else begin
            for (int n = 0; n < 16; n++) v[n] ^= rk[9][n];
            for (int r = 8; r >= 0; r--) begin
                v = undiffuse(v);
                for (int n = 0; n < 16; n++) v[n] = s_rev[v[n]] ^ rk[r][n];
            end
        end
        for (int n = 0; n < 16; n++) res[8*n +: 8] = v[n];
        return res;
    endfunction

    function automatic logic [63:0] rnd64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
                    t_txn t;
                    logic [127:0] r;
                    t = pending_q.pop_front();
                    r = cipher_block(t.op, t.hi, t.lo);
                    cipher_exp_q.push_back(r[127:64]);
                    cipher_exp_q.push_back(r[63:0]);
                    if (t.op) n_dec++; else n_enc++;
                    i_valid <= 1'b1;
                    i_opcode <= t.op;
                    i_block_high <= t.hi;
                    i_block_low <= t.lo;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= !no_idle && $urandom_range(0, 99) < 25;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (cipher_exp_q.size() == 0) begin
                $error("unexpected result %h_%h", o_result_high, o_result_low);
                n_errors++;
            end else begin
                logic [63:0] eh, el;
                eh = cipher_exp_q.pop_front();
                el = cipher_exp_q.pop_front();
                if (o_result_high !== eh) begin
                    $error("result_high exp %h got %h", eh, o_result_high);
                    n_errors++;
                end
                if (o_result_low !== el) begin
                    $error("result_low exp %h got %h", el, o_result_low);
                    n_errors++;
                end
                n_results++;
            end
        end
    end

    initial begin
        wait (cycle_cnt >= 400000);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_key(kuz_pkg::t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        key_regs[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || cipher_exp_q.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic queue_txn(logic op, logic [63:0] hi, logic [63:0] lo);
        t_txn t;
        t.op = op;
        t.hi = hi;
        t.lo = lo;
        pending_q.push_back(t);
    endtask

    initial begin
        for (int i = 0; i < 4; i++) key_regs[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // zero key after reset
        for (int op = 0; op < 2; op++) begin
            queue_txn(1'(op), '0, '0);
            queue_txn(1'(op), '1, '1);
            queue_txn(1'(op), 64'h1122334455667700, 64'hffeeddccbbaa9988);
        end
        drain();
        // standard key, plus all-ones key
        write_key(kuz_pkg::CFG_K1_HI, 64'h8899aabbccddeeff);
        write_key(kuz_pkg::CFG_K1_LO, 64'h0011223344556677);
        write_key(kuz_pkg::CFG_K2_HI, 64'hfedcba9876543210);
        write_key(kuz_pkg::CFG_K2_LO, 64'h0123456789abcdef);
        queue_txn(1'b0, 64'h1122334455667700, 64'hffeeddccbbaa9988);
        queue_txn(1'b1, 64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd);
        queue_txn(1'b0, 64'h8000000000000000, 64'h1);
        queue_txn(1'b1, 64'h8000000000000000, 64'h1);
        drain();
        for (int i = 0; i < 4; i++) write_key(kuz_pkg::t_cfg_idx'(i), '1);
        for (int op = 0; op < 2; op++) begin
            queue_txn(1'(op), '0, '1);
            queue_txn(1'(op), '1, '0);
        end
        drain();
        n_keys = 3;
        for (int ph = 0; ph < 12; ph++) begin
            for (int i = 0; i < 4; i++) write_key(kuz_pkg::t_cfg_idx'(i), rnd64());
            no_idle = (ph == 5);
            for (int k = 0; k < 160; k++)
                queue_txn(1'($urandom_range(0, 1)), rnd64(), rnd64());
            drain();
            n_keys++;
        end
        $display("Ran %0d encrypt and %0d decrypt blocks under %0d keys, %0d results.",
                 n_enc, n_dec, n_keys, n_results);
        if (n_errors == 0 && cipher_exp_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
